// ===== design/vxw_pkg.sv =====
// ----------------------------------------------------------------------------
// vxw_pkg
// shared types and constants for the vertex index welder: payload structs,
// register indexes, controller states and the controller/datapath signals
// ----------------------------------------------------------------------------
package vxw_pkg;

   // default sizing
   localparam int DEFAULT_TABLE_DEPTH = 1024;
   localparam int DEFAULT_MAX_STRIDE  = 8;

   // fixed field widths
   localparam int WORD_W     = 16;
   localparam int KEY_W      = 48;
   localparam int VNUM_W     = 10;
   localparam int WIC_W      = 3;
   localparam int STRIDE_W   = 4;
   localparam int OFFSET_W   = 3;
   localparam int STRIDE_CMP_W = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CORNER_STRIDE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POSITION_OFFSET = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NORMAL_OFFSET   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TEXCOORD_OFFSET = 2'd3;

   // input transaction
   typedef struct packed {
      logic [WORD_W-1:0] index_word;
      logic              mesh_start;
   } req_type;

   // result transaction
   typedef struct packed {
      logic [VNUM_W-1:0] vertex_number;
      logic              is_new;
      logic              overflow;
   } rsp_type;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_EMIT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic take;
      logic search;
      logic emit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic corner_done;
      logic found;
      logic miss;
      logic slot_free;
   } status_type;

endpackage

// ===== design/vxw_datapath.sv =====
// ----------------------------------------------------------------------------
// vxw_datapath
// config registers, corner capture, key table with sequential scan and the
// result register
// ----------------------------------------------------------------------------
module vxw_datapath #(
   parameter int TABLE_DEPTH = vxw_pkg::DEFAULT_TABLE_DEPTH,
   parameter int MAX_STRIDE  = vxw_pkg::DEFAULT_MAX_STRIDE
) (
   input  logic                           clock,
   input  logic                           reset,
   input  vxw_pkg::req_type               req_payload,
   input  logic                           csr_write_en,
   input  logic [vxw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [vxw_pkg::CSR_DATA_W-1:0] csr_data,
   input  vxw_pkg::cmd_type               cmd,
   output vxw_pkg::status_type            status,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output vxw_pkg::rsp_type               rsp_payload
);
   import vxw_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   // config registers
   logic [STRIDE_W-1:0] stride_ff;
   logic [OFFSET_W-1:0] pos_off_ff, nrm_off_ff, tex_off_ff;

   // corner capture
   logic [WIC_W-1:0]  wic_ff, wic_in, wic_base;
   logic [WORD_W-1:0] pos_ff, pos_in, pos_base;
   logic [WORD_W-1:0] nrm_ff, nrm_in, nrm_base;
   logic [WORD_W-1:0] tex_ff, tex_in, tex_base;
   logic [STRIDE_CMP_W-1:0] eff_stride;
   logic              corner_done;

   // table and scan
   logic [KEY_W-1:0] mem [TABLE_DEPTH];
   logic [CW-1:0]    count_ff;
   logic [CW-1:0]    rd_idx_ff;
   logic [AW-1:0]    cmp_idx_ff;
   logic             cmp_valid_ff;
   logic [KEY_W-1:0] rd_data_ff;
   logic [KEY_W-1:0] key_ff;
   logic             found, miss, step;
   logic [CW+VNUM_W-1:0] count_ext;
   logic [AW+VNUM_W-1:0] idx_ext;

   // result
   rsp_type pend_ff, pend_in;
   rsp_type rsp_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    slot_free;

   // config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         stride_ff  <= STRIDE_W'(1);
         pos_off_ff <= '0;
         nrm_off_ff <= '0;
         tex_off_ff <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_CORNER_STRIDE:   stride_ff  <= csr_data[STRIDE_W-1:0];
            CSR_POSITION_OFFSET: pos_off_ff <= csr_data[OFFSET_W-1:0];
            CSR_NORMAL_OFFSET:   nrm_off_ff <= csr_data[OFFSET_W-1:0];
            CSR_TEXCOORD_OFFSET: tex_off_ff <= csr_data[OFFSET_W-1:0];
            default: ;
         endcase
      end
   end

   // stride clamped to 1..MAX_STRIDE
   always_comb begin
      if (stride_ff == '0) begin
         eff_stride = STRIDE_CMP_W'(1);
      end else if ({1'b0, stride_ff} > STRIDE_CMP_W'(MAX_STRIDE)) begin
         eff_stride = STRIDE_CMP_W'(MAX_STRIDE);
      end else begin
         eff_stride = {1'b0, stride_ff};
      end
   end

   // capture of the word, a mesh start clears first
   always_comb begin
      wic_base = req_payload.mesh_start ? '0 : wic_ff;
      pos_base = req_payload.mesh_start ? '0 : pos_ff;
      nrm_base = req_payload.mesh_start ? '0 : nrm_ff;
      tex_base = req_payload.mesh_start ? '0 : tex_ff;
      pos_in = (wic_base == pos_off_ff) ? req_payload.index_word : pos_base;
      nrm_in = (wic_base == nrm_off_ff) ? req_payload.index_word : nrm_base;
      tex_in = (wic_base == tex_off_ff) ? req_payload.index_word : tex_base;
      corner_done = !((STRIDE_CMP_W'(wic_base) + STRIDE_CMP_W'(1)) < eff_stride);
      wic_in = corner_done ? '0 : wic_base + WIC_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wic_ff <= '0;
         pos_ff <= '0;
         nrm_ff <= '0;
         tex_ff <= '0;
      end else if (cmd.take) begin
         wic_ff <= wic_in;
         pos_ff <= pos_in;
         nrm_ff <= nrm_in;
         tex_ff <= tex_in;
      end
   end

   // key of the completed corner
   always_ff @(posedge clock) begin
      if (cmd.take && corner_done) begin
         key_ff <= {tex_in, nrm_in, pos_in};
      end
   end

   // scan outcome: keys in the table are unique, so any hit is the hit
   assign found = cmp_valid_ff && (rd_data_ff == key_ff);
   assign miss  = (rd_idx_ff >= count_ff) && !found;
   assign step  = cmd.search && !found && !miss;

   // scan pointer and compare slot
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_idx_ff    <= '0;
         cmp_valid_ff <= 1'b0;
      end else if (cmd.take) begin
         rd_idx_ff    <= '0;
         cmp_valid_ff <= 1'b0;
      end else if (step) begin
         rd_idx_ff    <= rd_idx_ff + CW'(1);
         cmp_valid_ff <= 1'b1;
      end
   end

   // table read, one entry a cycle
   always_ff @(posedge clock) begin
      if (step) begin
         rd_data_ff <= mem[rd_idx_ff[AW-1:0]];
         cmp_idx_ff <= rd_idx_ff[AW-1:0];
      end
   end

   // table write of a new vertex
   always_ff @(posedge clock) begin
      if (cmd.emit && pend_ff.is_new) begin
         mem[count_ff[AW-1:0]] <= key_ff;
      end
   end

   // vertex count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.take && req_payload.mesh_start) begin
         count_ff <= '0;
      end else if (cmd.emit && pend_ff.is_new) begin
         count_ff <= count_ff + CW'(1);
      end
   end

   // pending result of the scan
   assign count_ext = {{VNUM_W{1'b0}}, count_ff};
   assign idx_ext   = {{VNUM_W{1'b0}}, cmp_idx_ff};

   always_comb begin
      pend_in = pend_ff;
      if (found) begin
         pend_in.vertex_number = idx_ext[VNUM_W-1:0];
         pend_in.is_new        = 1'b0;
         pend_in.overflow      = 1'b0;
      end else if (count_ff >= CW'(TABLE_DEPTH)) begin
         pend_in.vertex_number = '0;
         pend_in.is_new        = 1'b0;
         pend_in.overflow      = 1'b1;
      end else begin
         pend_in.vertex_number = count_ext[VNUM_W-1:0];
         pend_in.is_new        = 1'b1;
         pend_in.overflow      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.search && (found || miss)) begin
         pend_ff <= pend_in;
      end
   end

   // result register
   assign slot_free    = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = cmd.emit || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_ff <= pend_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // status back to the controller
   assign status.corner_done = corner_done;
   assign status.found       = found;
   assign status.miss        = miss;
   assign status.slot_free   = slot_free;

endmodule

// ===== design/vxw_ctrl.sv =====
// ----------------------------------------------------------------------------
// vxw_ctrl
// sequencer: takes words, runs the table scan of a finished corner and
// hands the outcome to the result register
// ----------------------------------------------------------------------------
module vxw_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  vxw_pkg::status_type status,
   output vxw_pkg::cmd_type    cmd
);
   import vxw_pkg::*;

   state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && status.corner_done) begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (status.found || status.miss) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // outputs
   always_comb begin
      req_ready  = 1'b0;
      cmd.take   = 1'b0;
      cmd.search = 1'b0;
      cmd.emit   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.take  = req_valid;
         end
         ST_SEARCH: begin
            cmd.search = 1'b1;
         end
         ST_EMIT: begin
            cmd.emit = status.slot_free;
         end
         default: ;
      endcase
   end

endmodule

// ===== design/vertex_index_welder.sv =====
// ----------------------------------------------------------------------------
// vertex_index_welder
// welds the corners of an interleaved index list into unique vertex numbers
// ----------------------------------------------------------------------------
// req_* carries one index word per transaction with a mesh start flag that
// clears the table, the counters and the held indices before that word.
// Every corner_stride words complete a corner; its key (position, normal,
// texcoord) is scanned against the table, one stored key per cycle.
// rsp_* gives one transaction per completed corner: the vertex number, a
// new flag, and an overflow flag when a new key finds the table full.
// A word that finishes a corner starts a scan of the filled part of the
// single-port key memory, and no further word is taken until the scan
// ends and the result is loaded into the output register.
// The result sits in an output register, so the next word is taken while
// a result waits; when the receiver stalls and a second result is ready,
// the block holds it and stops taking words until the register frees.
// Reset returns the config registers to stride 1, offsets 0, and empties
// the table at once (a fill count marks the used entries, no clearing pass).
// csr_* writes a register; the user must write one only while the block is idle, the block does not enforce it.
// ----------------------------------------------------------------------------
module vertex_index_welder #(
   parameter int TABLE_DEPTH = vxw_pkg::DEFAULT_TABLE_DEPTH,
   parameter int MAX_STRIDE  = vxw_pkg::DEFAULT_MAX_STRIDE
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  vxw_pkg::req_type               req_payload,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output vxw_pkg::rsp_type               rsp_payload,
   input  logic                           csr_write_en,
   input  logic [vxw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [vxw_pkg::CSR_DATA_W-1:0] csr_data
);
   import vxw_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencer
   vxw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath
   vxw_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .MAX_STRIDE  (MAX_STRIDE)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_payload  (req_payload),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .cmd          (cmd),
      .status       (status),
      .rsp_ready    (rsp_ready),
      .rsp_valid    (rsp_valid),
      .rsp_payload  (rsp_payload)
   );

endmodule

// ===== design/vxw_checker.sv =====
// ----------------------------------------------------------------------------
// vxw_checker
// port-level checks on the welder, bound to the top level
// ----------------------------------------------------------------------------
module vxw_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input vxw_pkg::rsp_type rsp_payload
);
   import vxw_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("stalled result changed");

   // overflow never comes with a new vertex and always with number zero
   a_ovf_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.overflow) |->
         (!rsp_payload.is_new && (rsp_payload.vertex_number == '0)))
      else $error("overflow result with bad fields");

   // nothing pending out of reset, ready to take words
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> (!rsp_valid && req_ready))
      else $error("block not idle after reset");

   // a new result needs the block busy the cycle before
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !$past(rsp_valid)) |-> !$past(req_ready))
      else $error("result appeared without a table scan");

endmodule

bind vertex_index_welder vxw_checker u_vxw_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the vertex index welder
// ----------------------------------------------------------------------------
// Index words go in over a valid/ready channel. The sender works in bursts
// and the receiver stalls on a pattern of its own. Each accepted word goes
// through a corner and vertex table model kept in the bench, and completed
// corners queue the vertex number, new flag and overflow flag they should
// produce. The bench starts with a short script that covers:
//    reset values
//    the extremes of the words
//    every register, including stride zero and a stride above the maximum
//    offsets that never arrive
//    a stride lowered mid-corner
// A sequential fill then takes the table to full, with new keys overflowing
// and old keys still found. Random meshes follow under random register
// settings, with one long receiver hold-off to back the block up.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import vxw_pkg::*;

   localparam int TABLE_DEPTH     = DEFAULT_TABLE_DEPTH;
   localparam int MAX_STRIDE      = DEFAULT_MAX_STRIDE;
   localparam int RANDOM_WORDS    = 870;
   localparam int EXTRA_FILL      = 32;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int SETTLE_CYCLES   = 8;
   localparam int DRAIN_CYCLES    = 1100;
   localparam int TIME_LIMIT_NS   = 16_000_000;
   localparam int REPORT_LIMIT    = 10;

   // script rows: a register write or an index word
   typedef enum logic {ROW_WORD, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  sel;
      logic [CSR_DATA_W-1:0] value;
      logic [WORD_W-1:0]     word;
      logic                  start;
      logic                  known;
      rsp_type               want;
   } script_row_type;

   localparam int SCRIPT_ROWS = 35;

   localparam script_row_type DIRECTED_SCRIPT [0:SCRIPT_ROWS-1] = '{
      // reset settings: stride 1, every index from the one word
      '{ROW_WORD, CSR_CORNER_STRIDE,   4'd0,  16'h0000, 1'b0, 1'b1, '{10'd0, 1'b1, 1'b0}},
      '{ROW_WORD, CSR_CORNER_STRIDE,   4'd0,  16'hffff, 1'b0, 1'b1, '{10'd1, 1'b1, 1'b0}},
      '{ROW_WORD, CSR_CORNER_STRIDE,   4'd0,  16'h0000, 1'b0, 1'b1, '{10'd0, 1'b0, 1'b0}},
      '{ROW_WORD, CSR_CORNER_STRIDE,   4'd0,  16'hffff, 1'b1, 1'b1, '{10'd0, 1'b1, 1'b0}},
      '{ROW_WORD, CSR_CORNER_STRIDE,   4'd0,  16'h1234, 1'b0, 1'b1, '{10'd1, 1'b1, 1'b0}},
      // three-word corners, then the same corner again
      '{ROW_CSR,  CSR_CORNER_STRIDE,   4'd3,  16'h0000, 1'b0, 1'b0, '0},
      '{ROW_CSR,  CSR_NORMAL_OFFSET,   4'd1,  16'h0000, 1'b0, 1'b0, '0},
      '{ROW_CSR,  CSR_TEXCOORD_OFFSET, 4'd2,  16'h0000, 1'b0, 1'b0, '0},
      '{ROW_WORD, CSR_CORNER_STRIDE,   4'd0,  16'h0001, 1'b0, 1'b0, '0},
      '{ROW_WORD, CSR_CORNER_STRIDE,   4'd0,  16'h0002, 1'b0, 1'b0, '0},
      '{ROW_WORD, CSR_CORNER_STRIDE,   4'd0,  16'h0003, 1'b0, 1'b0, '0},
      '{ROW_WORD, CSR_CORNER_STRIDE,   4'd0,  16'h0001, 1'b0, 1'b0, '0},
      '{ROW_WORD, CSR_CORNER_STRIDE,   4'd0,  16'h0002, 1'b0, 1'b0, '0},
      '{ROW_WORD, CSR_CORNER_STRIDE,   4'd0,  16'h0003, 1'b0, 1'b0, '0},
      // stride zero acts as one; normal and texcoord words never arrive
      '{ROW_CSR,  CSR_CORNER_STRIDE,   4'd0,  16'h0000, 1'b0, 1'b0, '0},
      '{ROW_WORD, CSR_CORNER_STRIDE,   4'd0,  16'h00aa, 1'b0, 1'b0, '0},
      // stride above the maximum saturates; offset msb is dropped
      '{ROW_CSR,  CSR_CORNER_STRIDE,   4'd15, 16'h0000, 1'b0, 1'b0, '0},
      '{ROW_CSR,  CSR_POSITION_OFFSET, 4'd15, 16'h0000, 1'b0, 1'b0, '0},
      '{ROW_CSR,  CSR_NORMAL_OFFSET,   4'd8,  16'h0000, 1'b0, 1'b0, '0},
      '{ROW_CSR,  CSR_TEXCOORD_OFFSET, 4'd5,  16'h0000, 1'b0, 1'b0, '0},
      '{ROW_WORD, CSR_CORNER_STRIDE,   4'd0,  16'habcd, 1'b1, 1'b0, '0},
      '{ROW_WORD, CSR_CORNER_STRIDE,   4'd0,  16'h8001, 1'b0, 1'b0, '0},
      '{ROW_WORD, CSR_CORNER_STRIDE,   4'd0,  16'h7ffe, 1'b0, 1'b0, '0},
      '{ROW_WORD, CSR_CORNER_STRIDE,   4'd0,  16'h0f0f, 1'b0, 1'b0, '0},
      '{ROW_WORD, CSR_CORNER_STRIDE,   4'd0,  16'hf0f0, 1'b0, 1'b0, '0},
      '{ROW_WORD, CSR_CORNER_STRIDE,   4'd0,  16'h5555, 1'b0, 1'b0, '0},
      '{ROW_WORD, CSR_CORNER_STRIDE,   4'd0,  16'haaaa, 1'b0, 1'b0, '0},
      '{ROW_WORD, CSR_CORNER_STRIDE,   4'd0,  16'hffff, 1'b0, 1'b0, '0},
      // stride lowered with the corner already past its new end
      '{ROW_CSR,  CSR_CORNER_STRIDE,   4'd4,  16'h0000, 1'b0, 1'b0, '0},
      '{ROW_WORD, CSR_CORNER_STRIDE,   4'd0,  16'h0101, 1'b0, 1'b0, '0},
      '{ROW_WORD, CSR_CORNER_STRIDE,   4'd0,  16'h0202, 1'b0, 1'b0, '0},
      '{ROW_CSR,  CSR_CORNER_STRIDE,   4'd2,  16'h0000, 1'b0, 1'b0, '0},
      '{ROW_WORD, CSR_CORNER_STRIDE,   4'd0,  16'h0303, 1'b0, 1'b0, '0},
      '{ROW_WORD, CSR_CORNER_STRIDE,   4'd0,  16'h0404, 1'b0, 1'b0, '0},
      '{ROW_WORD, CSR_CORNER_STRIDE,   4'd0,  16'h0505, 1'b0, 1'b0, '0}
   };

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_payload;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_payload;
   logic                  csr_write_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   // register mirror
   logic [STRIDE_W-1:0] cfg_stride   = 4'd1;
   logic [OFFSET_W-1:0] cfg_position = '0;
   logic [OFFSET_W-1:0] cfg_normal   = '0;
   logic [OFFSET_W-1:0] cfg_texcoord = '0;

   // corner and vertex table model
   logic [WIC_W-1:0]  corner_word  = '0;
   logic [WORD_W-1:0] held_position = '0;
   logic [WORD_W-1:0] held_normal   = '0;
   logic [WORD_W-1:0] held_texcoord = '0;
   int                welded_count  = 0;
   int                vertex_of_key [logic [KEY_W-1:0]];

   rsp_type welded_due [$];
   int      fault_count = 0;
   int      burst_left  = 0;
   bit      hold_off_pending = 1'b0;

   vertex_index_welder uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_payload  (rsp_payload),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // run limit
   initial begin
      #TIME_LIMIT_NS;
      $display("TEST FAILED");
      $finish;
   end

   // one word into the model; returns 1 when it completes a corner
   function automatic bit weld_word(input req_type item, output rsp_type welded);
      int              span;
      logic [KEY_W-1:0] key;
      welded = '0;
      if (item.mesh_start) begin
         corner_word   = '0;
         held_position = '0;
         held_normal   = '0;
         held_texcoord = '0;
         welded_count  = 0;
         vertex_of_key.delete();
      end
      if (cfg_stride == 0)
         span = 1;
      else if (int'(cfg_stride) > MAX_STRIDE)
         span = MAX_STRIDE;
      else
         span = int'(cfg_stride);

      if (corner_word == cfg_position) held_position = item.index_word;
      if (corner_word == cfg_normal)   held_normal   = item.index_word;
      if (corner_word == cfg_texcoord) held_texcoord = item.index_word;

      if (int'(corner_word) + 1 < span) begin
         corner_word = corner_word + 1'b1;
         return 1'b0;
      end
      corner_word = '0;

      key = {held_texcoord, held_normal, held_position};
      if (vertex_of_key.exists(key)) begin
         welded.vertex_number = VNUM_W'(vertex_of_key[key]);
      end else if (welded_count >= TABLE_DEPTH) begin
         welded.overflow = 1'b1;
      end else begin
         vertex_of_key[key]   = welded_count;
         welded.vertex_number = VNUM_W'(welded_count);
         welded.is_new        = 1'b1;
         welded_count++;
      end
      return 1'b1;
   endfunction

   // register write, mirrored into the model
   task automatic write_reg(input logic [CSR_IDX_W-1:0] sel,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= sel;
      csr_data     <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
      case (sel)
         CSR_CORNER_STRIDE:   cfg_stride   = value;
         CSR_POSITION_OFFSET: cfg_position = value[OFFSET_W-1:0];
         CSR_NORMAL_OFFSET:   cfg_normal   = value[OFFSET_W-1:0];
         CSR_TEXCOORD_OFFSET: cfg_texcoord = value[OFFSET_W-1:0];
         default: ;
      endcase
   endtask

   // offer one word in bursts; a known result overrides the model's
   task automatic offer_word(input logic [WORD_W-1:0] word, input logic start,
                             input logic known, input rsp_type fixed);
      req_type item;
      rsp_type welded;
      int      gap;
      item.index_word = word;
      item.mesh_start = start;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      if (weld_word(item, welded))
         welded_due.insert(welded_due.size(), known ? fixed : welded);
   endtask

   // stop offering, let every result out, then give the block some cycles
   task automatic settle(input int cycles);
      @(negedge clock);
      req_valid <= 1'b0;
      while (welded_due.size() != 0) @(negedge clock);
      repeat (cycles) @(negedge clock);
   endtask

   function automatic logic [CSR_DATA_W-1:0] pick_offset();
      case ($urandom_range(0, 5))
         0:       return CSR_DATA_W'(0);
         1:       return CSR_DATA_W'(7);
         default: return CSR_DATA_W'($urandom_range(0, 15));
      endcase
   endfunction

   // result check against the oldest outstanding corner
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (welded_due.size() == 0) begin
            fault_count++;
            if (fault_count <= REPORT_LIMIT)
               $display("%0t: unexpected result vertex %0d new %0b overflow %0b", $realtime,
                        rsp_payload.vertex_number, rsp_payload.is_new, rsp_payload.overflow);
         end else begin
            want = welded_due.pop_front();
            if (rsp_payload.vertex_number !== want.vertex_number ||
                rsp_payload.is_new !== want.is_new ||
                rsp_payload.overflow !== want.overflow) begin
               fault_count++;
               if (fault_count <= REPORT_LIMIT)
                  $display("%0t: expected vertex %0d new %0b overflow %0b, got %0d %0b %0b",
                           $realtime, want.vertex_number, want.is_new, want.overflow,
                           rsp_payload.vertex_number, rsp_payload.is_new,
                           rsp_payload.overflow);
            end
         end
      end
   end

   // receiver stall pattern, with one long hold-off on request
   initial begin
      int mode;
      int span;
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_ready <= 1'b0;
            for (int held = 0; held < HOLD_OFF_CYCLES; held++) @(negedge clock);
         end
         mode = $urandom_range(0, 3);
         span = $urandom_range(1, 64);
         repeat (span) begin
            case (mode)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= 1'($urandom_range(0, 1));
               2:       rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= ($urandom_range(0, 7) != 0);
            endcase
            @(negedge clock);
         end
      end
   end

   // stimulus
   initial begin
      logic [WORD_W-1:0] base;
      logic [WORD_W-1:0] word;
      logic              start;
      int                pool;
      int                phase_len;
      int                random_done;
      bit                first_phase;

      reset        = 1'b1;
      req_valid    = 1'b0;
      req_payload  = '0;
      csr_write_en = 1'b0;
      csr_index    = CSR_CORNER_STRIDE;
      csr_data     = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed script
      foreach (DIRECTED_SCRIPT[r]) begin
         if (DIRECTED_SCRIPT[r].kind == ROW_CSR) begin
            settle(SETTLE_CYCLES);
            write_reg(DIRECTED_SCRIPT[r].sel, DIRECTED_SCRIPT[r].value);
         end else begin
            offer_word(DIRECTED_SCRIPT[r].word, DIRECTED_SCRIPT[r].start,
                       DIRECTED_SCRIPT[r].known, DIRECTED_SCRIPT[r].want);
         end
      end

      // fill the table with distinct keys, then probe it when full
      settle(SETTLE_CYCLES);
      write_reg(CSR_CORNER_STRIDE, CSR_DATA_W'(1));
      write_reg(CSR_POSITION_OFFSET, '0);
      write_reg(CSR_NORMAL_OFFSET, '0);
      write_reg(CSR_TEXCOORD_OFFSET, '0);
      base = WORD_W'($urandom);
      for (int i = 0; i < TABLE_DEPTH; i++)
         offer_word(base + WORD_W'(i), i == 0, 1'b0, '0);
      for (int i = 0; i < EXTRA_FILL; i++) begin
         if ($urandom_range(0, 1) == 0)
            word = base + WORD_W'($urandom_range(0, TABLE_DEPTH - 1));
         else
            word = base + WORD_W'(TABLE_DEPTH + $urandom_range(0, 60000));
         offer_word(word, 1'b0, 1'b0, '0);
      end

      // random meshes under random settings
      random_done = 0;
      first_phase = 1'b1;
      while (random_done < RANDOM_WORDS) begin
         settle(SETTLE_CYCLES);
         if (first_phase) begin
            // single-word corners so the held-off receiver backs the block up
            write_reg(CSR_CORNER_STRIDE, CSR_DATA_W'(1));
         end else begin
            case ($urandom_range(0, 5))
               0:       write_reg(CSR_CORNER_STRIDE, CSR_DATA_W'(0));
               1:       write_reg(CSR_CORNER_STRIDE, CSR_DATA_W'(1));
               2:       write_reg(CSR_CORNER_STRIDE, CSR_DATA_W'(MAX_STRIDE));
               3:       write_reg(CSR_CORNER_STRIDE, CSR_DATA_W'(15));
               default: write_reg(CSR_CORNER_STRIDE, CSR_DATA_W'($urandom_range(0, 15)));
            endcase
         end
         write_reg(CSR_POSITION_OFFSET, pick_offset());
         write_reg(CSR_NORMAL_OFFSET, pick_offset());
         write_reg(CSR_TEXCOORD_OFFSET, pick_offset());
         if (first_phase) hold_off_pending = 1'b1;
         first_phase = 1'b0;

         pool      = $urandom_range(1, 15);
         phase_len = $urandom_range(20, 60);
         for (int i = 0; i < phase_len; i++) begin
            // small index pool so keys repeat, with the odd full-range word
            if ($urandom_range(0, 7) == 0)
               word = WORD_W'($urandom);
            else
               word = WORD_W'($urandom_range(0, pool));
            // mesh starts on corner boundaries, with stray ones mid-corner
            if (corner_word == 0 && (welded_count > 48 || $urandom_range(0, 15) == 0))
               start = 1'b1;
            else
               start = ($urandom_range(0, 39) == 0);
            offer_word(word, start, 1'b0, '0);
            random_done++;
         end
      end

      settle(DRAIN_CYCLES);
      if (fault_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
